/* hw/rtl/sbt_pkg.sv */
// ----------------------------------------------------------------------------
// sbt_pkg: shared types and constants for the source byte tokenizer
// Token kinds, lexer modes, keyword prefix codes, character helpers and the
// packed token record passed from the lexer to the output queue.
// ----------------------------------------------------------------------------
package sbt_pkg;

  // Source size limit; offsets saturate at min(limit, 65536) - 1
  localparam int unsigned MAX_SOURCE_BYTES = 65536;
  localparam int unsigned OFFSET_CAP_INT =
    ((MAX_SOURCE_BYTES > 65536) ? 65536 : MAX_SOURCE_BYTES) - 1;
  localparam logic [15:0] OFFSET_CAP = 16'(OFFSET_CAP_INT);

  // Output queue sizing: room for two tokens per byte plus slack
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QFILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [QFILL_W-1:0] QUEUE_ROOM_LIMIT = QFILL_W'(QUEUE_DEPTH - 2);

  // Stream widths
  localparam int unsigned IN_DATA_W = 8;
  localparam int unsigned OUT_DATA_W = 48;

  // Token kinds
  localparam logic [3:0] KIND_ILLEGAL = 4'd0;
  localparam logic [3:0] KIND_EOF     = 4'd1;
  localparam logic [3:0] KIND_IDENT   = 4'd2;
  localparam logic [3:0] KIND_INT     = 4'd3;
  localparam logic [3:0] KIND_FN      = 4'd4;
  localparam logic [3:0] KIND_LET     = 4'd5;
  localparam logic [3:0] KIND_STRING  = 4'd6;
  localparam logic [3:0] KIND_ASSIGN  = 4'd7;
  localparam logic [3:0] KIND_SEMI    = 4'd8;
  localparam logic [3:0] KIND_LPAREN  = 4'd9;
  localparam logic [3:0] KIND_RPAREN  = 4'd10;
  localparam logic [3:0] KIND_COMMA   = 4'd11;
  localparam logic [3:0] KIND_PLUS    = 4'd12;
  localparam logic [3:0] KIND_LBRACE  = 4'd13;
  localparam logic [3:0] KIND_RBRACE  = 4'd14;
  localparam logic [3:0] KIND_UNTERM  = 4'd15;

  // Keyword prefix tracking
  localparam logic [2:0] KW_NONE = 3'd0;
  localparam logic [2:0] KW_F    = 3'd1;
  localparam logic [2:0] KW_FN   = 3'd2;
  localparam logic [2:0] KW_L    = 3'd3;
  localparam logic [2:0] KW_LE   = 3'd4;
  localparam logic [2:0] KW_LET  = 3'd5;

  // Characters of interest
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_ASSIGN = 8'h3D;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_E   = 8'h65;
  localparam logic [7:0] CH_LO_F   = 8'h66;
  localparam logic [7:0] CH_LO_L   = 8'h6C;
  localparam logic [7:0] CH_LO_N   = 8'h6E;
  localparam logic [7:0] CH_LO_T   = 8'h74;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // Lexer mode, one-hot
  typedef enum logic [3:0] {
    MODE_IDLE  = 4'b0001,
    MODE_NUM   = 4'b0010,
    MODE_IDENT = 4'b0100,
    MODE_STR   = 4'b1000
  } lex_mode_t;

  // One emitted token
  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic [7:0]  sym;
    logic        last;
  } token_t;

  // Lexer results for one accepted byte
  typedef struct packed {
    logic [1:0] count;
    token_t     tok0;
    token_t     tok1;
  } lex_result_t;

  // Lexer status seen by the top level
  typedef struct packed {
    lex_mode_t   mode;
    logic [15:0] offset;
  } lex_status_t;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v >= OFFSET_CAP) ? OFFSET_CAP : v + 16'd1;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= CH_UP_A) && (c <= CH_UP_Z)) || ((c >= CH_LO_A) && (c <= CH_LO_Z));
  endfunction

  function automatic logic [3:0] symbol_kind(input logic [7:0] c);
    logic [3:0] k;
    unique case (c)
      CH_ASSIGN: k = KIND_ASSIGN;
      CH_SEMI:   k = KIND_SEMI;
      CH_LPAREN: k = KIND_LPAREN;
      CH_RPAREN: k = KIND_RPAREN;
      CH_COMMA:  k = KIND_COMMA;
      CH_PLUS:   k = KIND_PLUS;
      CH_LBRACE: k = KIND_LBRACE;
      CH_RBRACE: k = KIND_RBRACE;
      default:   k = KIND_ILLEGAL;
    endcase
    return k;
  endfunction

endpackage

/* hw/rtl/sbt_lexer.sv */
// ----------------------------------------------------------------------------
// sbt_lexer: per-byte lexer state and token generation
// Holds mode, offset, lexeme start and keyword prefix; for each accepted
// byte it forms up to two tokens in one pass of combinational logic.
// ----------------------------------------------------------------------------
module sbt_lexer (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [7:0]           source_byte,
  output sbt_pkg::lex_result_t result,
  output sbt_pkg::lex_status_t status
);

  sbt_pkg::lex_mode_t mode, mode_next;
  logic [15:0] offset, offset_next;
  logic [15:0] lexeme_start, lexeme_start_next;
  logic [2:0]  keyword_match, keyword_match_next;

  sbt_pkg::token_t tok_a, tok_b;
  logic            a_valid, b_valid;
  logic            do_idle, reset_offset;
  logic [15:0]     run_length;

  assign run_length = (offset >= lexeme_start) ? offset - lexeme_start : 16'd0;

  // Close the open run if the byte ends it, then handle the byte as in idle mode unless it was a closing quote
  always_comb begin
    mode_next          = mode;
    lexeme_start_next  = lexeme_start;
    keyword_match_next = keyword_match;
    offset_next        = offset;
    tok_a              = '0;
    tok_b              = '0;
    a_valid            = 1'b0;
    b_valid            = 1'b0;
    do_idle            = 1'b0;
    reset_offset       = 1'b0;

    tok_a.start  = lexeme_start;
    tok_a.length = run_length;

    unique case (mode)
      sbt_pkg::MODE_NUM: begin
        if (!sbt_pkg::is_digit(source_byte)) begin
          a_valid    = 1'b1;
          tok_a.kind = sbt_pkg::KIND_INT;
          mode_next  = sbt_pkg::MODE_IDLE;
          do_idle    = 1'b1;
        end
      end
      sbt_pkg::MODE_IDENT: begin
        if (sbt_pkg::is_alpha(source_byte)) begin
          if (keyword_match == sbt_pkg::KW_F && source_byte == sbt_pkg::CH_LO_N) begin
            keyword_match_next = sbt_pkg::KW_FN;
          end else if (keyword_match == sbt_pkg::KW_L && source_byte == sbt_pkg::CH_LO_E) begin
            keyword_match_next = sbt_pkg::KW_LE;
          end else if (keyword_match == sbt_pkg::KW_LE && source_byte == sbt_pkg::CH_LO_T) begin
            keyword_match_next = sbt_pkg::KW_LET;
          end else begin
            keyword_match_next = sbt_pkg::KW_NONE;
          end
        end else begin
          a_valid = 1'b1;
          if (keyword_match == sbt_pkg::KW_FN) begin
            tok_a.kind = sbt_pkg::KIND_FN;
          end else if (keyword_match == sbt_pkg::KW_LET) begin
            tok_a.kind = sbt_pkg::KIND_LET;
          end else begin
            tok_a.kind = sbt_pkg::KIND_IDENT;
          end
          keyword_match_next = sbt_pkg::KW_NONE;
          mode_next          = sbt_pkg::MODE_IDLE;
          do_idle            = 1'b1;
        end
      end
      sbt_pkg::MODE_STR: begin
        if (source_byte == sbt_pkg::CH_QUOTE) begin
          a_valid    = 1'b1;
          tok_a.kind = sbt_pkg::KIND_STRING;
          mode_next  = sbt_pkg::MODE_IDLE;
        end else if (source_byte == sbt_pkg::CH_NUL) begin
          a_valid    = 1'b1;
          tok_a.kind = sbt_pkg::KIND_UNTERM;
          mode_next  = sbt_pkg::MODE_IDLE;
          do_idle    = 1'b1;
        end
      end
      default: begin
        do_idle = 1'b1;
      end
    endcase

    // Idle handling of the byte
    if (do_idle) begin
      if (sbt_pkg::is_space(source_byte)) begin
        mode_next = sbt_pkg::MODE_IDLE;
      end else if (sbt_pkg::is_digit(source_byte)) begin
        mode_next         = sbt_pkg::MODE_NUM;
        lexeme_start_next = offset;
      end else if (sbt_pkg::is_alpha(source_byte)) begin
        mode_next         = sbt_pkg::MODE_IDENT;
        lexeme_start_next = offset;
        if (source_byte == sbt_pkg::CH_LO_F) begin
          keyword_match_next = sbt_pkg::KW_F;
        end else if (source_byte == sbt_pkg::CH_LO_L) begin
          keyword_match_next = sbt_pkg::KW_L;
        end else begin
          keyword_match_next = sbt_pkg::KW_NONE;
        end
      end else if (source_byte == sbt_pkg::CH_QUOTE) begin
        mode_next         = sbt_pkg::MODE_STR;
        lexeme_start_next = sbt_pkg::sat_inc(offset);
      end else if (source_byte == sbt_pkg::CH_NUL) begin
        b_valid      = 1'b1;
        tok_b.kind   = sbt_pkg::KIND_EOF;
        tok_b.start  = offset;
        reset_offset = 1'b1;
      end else begin
        b_valid      = 1'b1;
        tok_b.kind   = sbt_pkg::symbol_kind(source_byte);
        tok_b.start  = offset;
        tok_b.length = 16'd1;
        tok_b.sym    = source_byte;
      end
    end

    // Advance the offset, or restart after end of input
    if (reset_offset) begin
      offset_next        = '0;
      lexeme_start_next  = '0;
      keyword_match_next = sbt_pkg::KW_NONE;
      mode_next          = sbt_pkg::MODE_IDLE;
    end else begin
      offset_next = sbt_pkg::sat_inc(offset);
    end
  end

  // Order the tokens; the last one carries the run mark
  always_comb begin
    result       = '0;
    result.count = {1'b0, a_valid} + {1'b0, b_valid};
    if (a_valid) begin
      result.tok0      = tok_a;
      result.tok0.last = !b_valid;
      result.tok1      = tok_b;
      result.tok1.last = 1'b1;
    end else begin
      result.tok0      = tok_b;
      result.tok0.last = 1'b1;
    end
  end

  // Update lexer state on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= sbt_pkg::MODE_IDLE;
      offset        <= '0;
      lexeme_start  <= '0;
      keyword_match <= sbt_pkg::KW_NONE;
    end else if (accept) begin
      mode          <= mode_next;
      offset        <= offset_next;
      lexeme_start  <= lexeme_start_next;
      keyword_match <= keyword_match_next;
    end
  end

  assign status.mode   = mode;
  assign status.offset = offset;

endmodule

/* hw/rtl/sbt_out_queue.sv */
// ----------------------------------------------------------------------------
// sbt_out_queue: token result queue
// Small register queue that takes zero, one or two tokens per transaction on the
// input side and hands out one token per transaction on the output side.
// ----------------------------------------------------------------------------
module sbt_out_queue (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  input  sbt_pkg::lex_result_t                result,
  input  logic                                pop,
  output sbt_pkg::token_t                     head,
  output logic                                not_empty,
  output logic                                has_room,
  output logic [sbt_pkg::QFILL_W-1:0]         fill
);

  sbt_pkg::token_t entries [sbt_pkg::QUEUE_DEPTH];

  logic [sbt_pkg::QPTR_W-1:0]  wr_ptr, rd_ptr;
  logic [sbt_pkg::QPTR_W-1:0]  wr_ptr_next, rd_ptr_next;
  logic [sbt_pkg::QFILL_W-1:0] fill_next;
  logic [sbt_pkg::QFILL_W-1:0] push_count;
  logic [sbt_pkg::QPTR_W-1:0]  wr_ptr_second;

  assign push_count    = push ? sbt_pkg::QFILL_W'(result.count) : '0;
  assign wr_ptr_second = wr_ptr + sbt_pkg::QPTR_W'(1);
  assign wr_ptr_next   = wr_ptr + sbt_pkg::QPTR_W'(push_count);
  assign rd_ptr_next   = rd_ptr + sbt_pkg::QPTR_W'(pop);
  assign fill_next     = fill + push_count - sbt_pkg::QFILL_W'(pop);

  // Store incoming tokens
  always_ff @(posedge clk) begin
    if (push && result.count != 2'd0) begin
      entries[wr_ptr] <= result.tok0;
    end
    if (push && result.count == 2'd2) begin
      entries[wr_ptr_second] <= result.tok1;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      fill   <= fill_next;
    end
  end

  assign head      = entries[rd_ptr];
  assign not_empty = (fill != '0);
  assign has_room  = (fill <= sbt_pkg::QUEUE_ROOM_LIMIT);

endmodule

/* hw/rtl/source_byte_tokenizer_core.sv */
// ----------------------------------------------------------------------------
// source_byte_tokenizer_core: byte-serial source tokenizer
// Turns a stream of source bytes into tokens of kind, start offset, length
// and symbol byte, marking the last token caused by each byte.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one source byte per transaction; a zero byte ends the
//   text, emits eof and restarts offsets at zero.
//   Output channel m_*: one token per transaction; m_tlast marks the final
//   token caused by one input byte (a byte causes zero, one or two tokens).
// Path: tokens of an accepted byte are registered in the queue, then leave on m_*.
// Throughput: one byte per cycle while s_tready is high. The lexer state
//   updates once per accepted byte; a four-entry token queue sits between
//   lexer and output, and s_tready is high while it has room for two tokens.
//   A byte that causes two tokens needs two output transactions, so a run of
//   such bytes drains at one token per cycle while m_tready is high.
// Reset: rst (synchronous) returns to idle mode at offset zero and empties
//   the queue.
// Stall: while m_tready is low tokens collect in the queue; s_tready drops
//   once fewer than two entries are free, and no token is lost.
// ----------------------------------------------------------------------------
module source_byte_tokenizer_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [sbt_pkg::IN_DATA_W-1:0]   s_tdata,  // [7:0] source_byte
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [3:0] token_kind, [19:4] token_start, [35:20] token_length,
  // [43:36] symbol_byte, [47:44] zero
  output logic [sbt_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic                            m_tlast   // last_of_run
);

  sbt_pkg::lex_result_t        result;
  sbt_pkg::lex_status_t        status;
  sbt_pkg::token_t             head;
  logic                        in_accept, out_accept;
  logic                        has_room, not_empty;
  logic [sbt_pkg::QFILL_W-1:0] fill;

  assign in_accept  = s_tvalid && s_tready;
  assign out_accept = m_tvalid && m_tready;

  // Lexer state and token generation
  sbt_lexer u_lexer (
    .clk         (clk),
    .rst         (rst),
    .accept      (in_accept),
    .source_byte (s_tdata),
    .result      (result),
    .status      (status)
  );

  // Token queue toward the output channel
  sbt_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_accept),
    .result    (result),
    .pop       (out_accept),
    .head      (head),
    .not_empty (not_empty),
    .has_room  (has_room),
    .fill      (fill)
  );

  assign s_tready = has_room;
  assign m_tvalid = not_empty;
  assign m_tlast  = head.last;
  assign m_tdata  = {4'b0000, head.sym, head.length, head.start, head.kind};

  // End of input restarts the lexer at offset zero in idle mode
  assert property (@(posedge clk) disable iff (rst)
    (in_accept && s_tdata == sbt_pkg::CH_NUL) |=>
      (status.offset == 16'd0 && status.mode == sbt_pkg::MODE_IDLE))
    else $error("lexer not restarted after end of input");

  // Queue never overfills
  assert property (@(posedge clk) disable iff (rst)
    fill <= sbt_pkg::QFILL_W'(sbt_pkg::QUEUE_DEPTH))
    else $error("token queue overflow");

  // Queue level holds when neither side moves a transaction
  assert property (@(posedge clk) disable iff (rst)
    (!in_accept && !out_accept) |=> $stable(fill))
    else $error("token queue level changed without a transaction");

  // Offset never passes the saturation cap
  assert property (@(posedge clk) disable iff (rst)
    status.offset <= sbt_pkg::OFFSET_CAP)
    else $error("byte offset beyond cap");

endmodule

/* tb/source_byte_tokenizer_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// source_byte_tokenizer_core_tb: self-checking bench for the byte tokenizer
// Streams source text into the tokenizer and checks every token against a
// behavioral lexer kept in the bench. Directed text covers each symbol,
// keywords, runs ended by another byte, and strings closed and open at end of
// input. Then comes random text, mostly well-formed tokens with noise mixed
// in. Both stream sides idle and stall at random, except during one stretch
// at full rate.
// ----------------------------------------------------------------------------
module source_byte_tokenizer_core_tb;

  logic                           clk;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [sbt_pkg::IN_DATA_W-1:0]  s_tdata = '0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [sbt_pkg::OUT_DATA_W-1:0] m_tdata;
  logic                           m_tlast;

  // Behavioral lexer state
  sbt_pkg::lex_mode_t cur_mode = sbt_pkg::MODE_IDLE;
  logic [15:0]        cur_offset = '0;
  logic [15:0]        run_start = '0;
  logic [2:0]         kw_seen = sbt_pkg::KW_NONE;
  sbt_pkg::token_t    pending_tokens[$];

  bit gaps_on = 1'b1;
  int bytes_sent = 0;
  int content_bytes = 0;
  int tokens_checked = 0;
  int double_bytes = 0;
  int eof_count = 0;
  int mismatches = 0;

  source_byte_tokenizer_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop for a hung run
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Character classes
  function automatic bit char_is_blank(input logic [7:0] c);
    return (c == sbt_pkg::CH_SPACE) || (c >= sbt_pkg::CH_TAB && c <= sbt_pkg::CH_CR);
  endfunction

  function automatic bit char_is_digit(input logic [7:0] c);
    return c >= sbt_pkg::CH_ZERO && c <= sbt_pkg::CH_NINE;
  endfunction

  function automatic bit char_is_letter(input logic [7:0] c);
    return (c >= sbt_pkg::CH_UP_A && c <= sbt_pkg::CH_UP_Z) ||
           (c >= sbt_pkg::CH_LO_A && c <= sbt_pkg::CH_LO_Z);
  endfunction

  function automatic logic [3:0] punct_kind(input logic [7:0] c);
    case (c)
      sbt_pkg::CH_ASSIGN: return sbt_pkg::KIND_ASSIGN;
      sbt_pkg::CH_SEMI:   return sbt_pkg::KIND_SEMI;
      sbt_pkg::CH_LPAREN: return sbt_pkg::KIND_LPAREN;
      sbt_pkg::CH_RPAREN: return sbt_pkg::KIND_RPAREN;
      sbt_pkg::CH_COMMA:  return sbt_pkg::KIND_COMMA;
      sbt_pkg::CH_PLUS:   return sbt_pkg::KIND_PLUS;
      sbt_pkg::CH_LBRACE: return sbt_pkg::KIND_LBRACE;
      sbt_pkg::CH_RBRACE: return sbt_pkg::KIND_RBRACE;
      default:            return sbt_pkg::KIND_ILLEGAL;
    endcase
  endfunction

  function automatic logic [15:0] offset_step(input logic [15:0] v);
    return (v >= sbt_pkg::OFFSET_CAP) ? sbt_pkg::OFFSET_CAP : v + 16'd1;
  endfunction

  function automatic sbt_pkg::token_t make_token(input logic [3:0] kind,
                                                 input logic [15:0] start,
                                                 input logic [15:0] length,
                                                 input logic [7:0] sym);
    sbt_pkg::token_t t;
    t.kind = kind;
    t.start = start;
    t.length = length;
    t.sym = sym;
    t.last = 1'b0;
    return t;
  endfunction

  // Advance the lexer by one accepted byte and queue the tokens it causes
  function automatic void lex_byte(input logic [7:0] c);
    sbt_pkg::token_t toks[$];
    logic [15:0]     span;
    logic [3:0]      kind;
    bit              handled;
    bit              restart;
    handled = 1'b0;
    restart = 1'b0;
    span = (cur_offset >= run_start) ? cur_offset - run_start : 16'd0;

    // Close or extend the open lexeme
    case (cur_mode)
      sbt_pkg::MODE_NUM: begin
        if (char_is_digit(c)) begin
          handled = 1'b1;
        end else begin
          toks.push_back(make_token(sbt_pkg::KIND_INT, run_start, span, 8'h00));
          cur_mode = sbt_pkg::MODE_IDLE;
        end
      end
      sbt_pkg::MODE_IDENT: begin
        if (char_is_letter(c)) begin
          if (kw_seen == sbt_pkg::KW_F && c == sbt_pkg::CH_LO_N) kw_seen = sbt_pkg::KW_FN;
          else if (kw_seen == sbt_pkg::KW_L && c == sbt_pkg::CH_LO_E) kw_seen = sbt_pkg::KW_LE;
          else if (kw_seen == sbt_pkg::KW_LE && c == sbt_pkg::CH_LO_T) kw_seen = sbt_pkg::KW_LET;
          else kw_seen = sbt_pkg::KW_NONE;
          handled = 1'b1;
        end else begin
          kind = (kw_seen == sbt_pkg::KW_FN) ? sbt_pkg::KIND_FN :
                 (kw_seen == sbt_pkg::KW_LET) ? sbt_pkg::KIND_LET : sbt_pkg::KIND_IDENT;
          toks.push_back(make_token(kind, run_start, span, 8'h00));
          kw_seen = sbt_pkg::KW_NONE;
          cur_mode = sbt_pkg::MODE_IDLE;
        end
      end
      sbt_pkg::MODE_STR: begin
        if (c == sbt_pkg::CH_QUOTE) begin
          toks.push_back(make_token(sbt_pkg::KIND_STRING, run_start, span, 8'h00));
          cur_mode = sbt_pkg::MODE_IDLE;
          handled = 1'b1;
        end else if (c != sbt_pkg::CH_NUL) begin
          handled = 1'b1;
        end else begin
          toks.push_back(make_token(sbt_pkg::KIND_UNTERM, run_start, span, 8'h00));
          cur_mode = sbt_pkg::MODE_IDLE;
        end
      end
      default: ;
    endcase

    // Treat the byte as the start of something new
    if (!handled) begin
      if (char_is_blank(c)) begin
      end else if (char_is_digit(c)) begin
        cur_mode = sbt_pkg::MODE_NUM;
        run_start = cur_offset;
      end else if (char_is_letter(c)) begin
        cur_mode = sbt_pkg::MODE_IDENT;
        run_start = cur_offset;
        kw_seen = (c == sbt_pkg::CH_LO_F) ? sbt_pkg::KW_F :
                  (c == sbt_pkg::CH_LO_L) ? sbt_pkg::KW_L : sbt_pkg::KW_NONE;
      end else if (c == sbt_pkg::CH_QUOTE) begin
        cur_mode = sbt_pkg::MODE_STR;
        run_start = offset_step(cur_offset);
      end else if (c == sbt_pkg::CH_NUL) begin
        toks.push_back(make_token(sbt_pkg::KIND_EOF, cur_offset, 16'd0, 8'h00));
        restart = 1'b1;
        eof_count++;
      end else begin
        toks.push_back(make_token(punct_kind(c), cur_offset, 16'd1, c));
      end
    end

    if (restart) begin
      cur_offset = '0;
      run_start = '0;
      kw_seen = sbt_pkg::KW_NONE;
      cur_mode = sbt_pkg::MODE_IDLE;
    end else begin
      cur_offset = offset_step(cur_offset);
    end

    if (toks.size() > 0) toks[toks.size()-1].last = 1'b1;
    if (toks.size() == 2) double_bytes++;
    foreach (toks[i]) pending_tokens.push_back(toks[i]);
  endfunction

  task automatic report_mismatch(input string field, input logic [47:0] want,
                                 input logic [47:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch in %s, token %0d: expected %0h, got %0h",
               field, tokens_checked, want, got);
    end
  endtask

  // Random output stall
  always @(posedge clk) begin
    m_tready <= !(gaps_on && $urandom_range(99) < 17);
  end

  // Compare each token with the oldest expected one
  always @(posedge clk) begin
    sbt_pkg::token_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_tokens.size() == 0) begin
        report_mismatch("unexpected token", '0, m_tdata);
      end else begin
        want = pending_tokens.pop_front();
        if (m_tdata[3:0] !== want.kind)
          report_mismatch("token_kind", 48'(want.kind), 48'(m_tdata[3:0]));
        if (m_tdata[19:4] !== want.start)
          report_mismatch("token_start", 48'(want.start), 48'(m_tdata[19:4]));
        if (m_tdata[35:20] !== want.length)
          report_mismatch("token_length", 48'(want.length), 48'(m_tdata[35:20]));
        if (m_tdata[43:36] !== want.sym)
          report_mismatch("symbol_byte", 48'(want.sym), 48'(m_tdata[43:36]));
        if (m_tdata[47:44] !== 4'h0)
          report_mismatch("tdata padding", '0, 48'(m_tdata[47:44]));
        if (m_tlast !== want.last)
          report_mismatch("last_of_run", 48'(want.last), 48'(m_tlast));
      end
      tokens_checked++;
    end
  end

  // Offer one byte, hold it until accepted, then predict its tokens
  task automatic send_byte(input logic [7:0] c);
    while (gaps_on && $urandom_range(99) < 17) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= c;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    lex_byte(c);
    bytes_sent++;
    if (!char_is_blank(c)) content_bytes++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Drop valid and let every expected token come out
  task automatic drain_tokens();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_letter();
    return $urandom_range(1) ? 8'(sbt_pkg::CH_UP_A + $urandom_range(25)) :
                               8'(sbt_pkg::CH_LO_A + $urandom_range(25));
  endfunction

  function automatic logic [7:0] pick_blank();
    return ($urandom_range(5) == 0) ? sbt_pkg::CH_SPACE :
                                      8'(sbt_pkg::CH_TAB + $urandom_range(4));
  endfunction

  function automatic logic [7:0] pick_illegal();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(1, 255));
    end while (char_is_blank(c) || char_is_digit(c) || char_is_letter(c) ||
               c == sbt_pkg::CH_QUOTE || punct_kind(c) != sbt_pkg::KIND_ILLEGAL);
    return c;
  endfunction

  function automatic logic [7:0] pick_string_byte();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(1, 255));
    end while (c == sbt_pkg::CH_QUOTE);
    return c;
  endfunction

  // Random text: mostly well-formed tokens, some noise and open strings
  task automatic random_text(input int items);
    int         goal;
    int         pick;
    logic [7:0] punct[8];
    punct = '{sbt_pkg::CH_ASSIGN, sbt_pkg::CH_SEMI, sbt_pkg::CH_LPAREN,
              sbt_pkg::CH_RPAREN, sbt_pkg::CH_COMMA, sbt_pkg::CH_PLUS,
              sbt_pkg::CH_LBRACE, sbt_pkg::CH_RBRACE};
    goal = content_bytes + items;
    while (content_bytes < goal) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        send_text("fn");
      end else if (pick < 20) begin
        send_text("let");
      end else if (pick < 35) begin
        // Identifiers, often sharing a keyword prefix
        case ($urandom_range(3))
          0: send_byte(sbt_pkg::CH_LO_F);
          1: send_text("le");
          default: send_byte(pick_letter());
        endcase
        repeat ($urandom_range(5)) send_byte(pick_letter());
      end else if (pick < 50) begin
        repeat ($urandom_range(1, 5)) send_byte(8'(sbt_pkg::CH_ZERO + $urandom_range(9)));
      end else if (pick < 60) begin
        send_byte(sbt_pkg::CH_QUOTE);
        repeat ($urandom_range(6)) send_byte(pick_string_byte());
        send_byte(($urandom_range(99) < 85) ? sbt_pkg::CH_QUOTE : sbt_pkg::CH_NUL);
      end else if (pick < 78) begin
        send_byte(punct[$urandom_range(7)]);
      end else if (pick < 84) begin
        send_byte(pick_illegal());
      end else if (pick < 90) begin
        send_byte(8'($urandom_range(255)));
      end else if (pick < 94) begin
        send_byte(sbt_pkg::CH_NUL);
      end else begin
        repeat ($urandom_range(1, 3)) send_byte(pick_blank());
      end
      if ($urandom_range(1)) send_byte(pick_blank());
    end
  endtask

  task automatic test_symbols_and_illegal();
    send_text("=;(),+{}");
    send_byte(8'hFF);
    send_byte(8'h01);
    drain_tokens();
  endtask

  task automatic test_keywords_and_runs();
    // let, fn, an identifier cut off by a digit, then an open string at eof
    send_text("let\tfn=f9 \"a");
    send_byte(sbt_pkg::CH_NUL);
    drain_tokens();
  endtask

  task automatic test_string_cases();
    send_text("\"ok\"7");
    send_byte(sbt_pkg::CH_NUL);
    drain_tokens();
  endtask

  task automatic test_random_text();
    random_text(900);
    drain_tokens();
  endtask

  task automatic test_back_to_back();
    gaps_on = 1'b0;
    random_text(250);
    drain_tokens();
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_symbols_and_illegal();
    test_keywords_and_runs();
    test_string_cases();
    test_random_text();
    test_back_to_back();
    $display("Sent %0d bytes (%0d non-blank), checked %0d tokens", bytes_sent,
             content_bytes, tokens_checked);
    $display("Bytes giving two tokens: %0d, end-of-input tokens: %0d, mismatches: %0d",
             double_bytes, eof_count, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* source_byte_tokenizer_core.f */
hw/rtl/sbt_pkg.sv
hw/rtl/sbt_lexer.sv
hw/rtl/sbt_out_queue.sv
hw/rtl/source_byte_tokenizer_core.sv
tb/source_byte_tokenizer_core_tb.sv
